// ----- hdl/lkf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types, constants, scratch memory map and microprogram for the
// fixed-point Kalman filter step.
// ----------------------------------------------------------------------------
package lkf_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t ONE_Q    = word_t'(1) <<< FRAC_W;

  // load targets
  localparam logic [2:0] TGT_A = 3'd0;
  localparam logic [2:0] TGT_C = 3'd1;
  localparam logic [2:0] TGT_Q = 3'd2;
  localparam logic [2:0] TGT_R = 3'd3;
  localparam logic [2:0] TGT_P = 3'd4;
  localparam logic [2:0] TGT_X = 3'd5;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // scratch memory map, all matrices row-major
  localparam addr_t BASE_A   = 7'd0;
  localparam addr_t BASE_C   = 7'd16;
  localparam addr_t BASE_Q   = 7'd24;
  localparam addr_t BASE_R   = 7'd40;
  localparam addr_t BASE_P   = 7'd44;
  localparam addr_t BASE_K   = 7'd60;
  localparam addr_t BASE_X   = 7'd68;
  localparam addr_t BASE_XP  = 7'd72;
  localparam addr_t BASE_T1  = 7'd76;
  localparam addr_t BASE_T2  = 7'd92;
  localparam addr_t BASE_S   = 7'd108;
  localparam addr_t BASE_SI  = 7'd112;
  localparam addr_t BASE_DET = 7'd116;
  localparam addr_t BASE_Y   = 7'd117;
  localparam addr_t BASE_CX  = 7'd119;
  localparam addr_t BASE_KV  = 7'd121;
  localparam addr_t STEP_M1  = 7'd127;  // stride of -1 modulo the depth

  typedef logic [4:0] op_idx_t;
  localparam op_idx_t OP_DET    = 5'd7;
  localparam op_idx_t OP_GAIN   = 5'd8;
  localparam op_idx_t OP_PCOPY  = 5'd17;
  localparam op_idx_t OP_XCOPY  = 5'd18;

  typedef enum logic [1:0] {
    B_PLAIN,
    B_NEG,
    B_ZERO
  } bmode_e;

  typedef struct packed {
    logic   mul;    // product term, else elementwise a + b
    logic   aid;    // a operand is the identity
    bmode_e bmode;
    logic   negt;   // subtract the second term
    logic [1:0] rl, cl, kl;  // last row, column, term index
    addr_t  ab, ai, aj, at;
    addr_t  bb, bi, bj, bt;
    addr_t  ob, oi, oj;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WY0,
    ST_WY1,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_CHK_RD,
    ST_CHK,
    ST_DRD,
    ST_DGO,
    ST_DWAIT,
    ST_ORD,
    ST_OVLD
  } state_e;

  function automatic op_t mk_op(
    input logic mul, input logic aid, input bmode_e bm, input logic negt,
    input logic [1:0] rl, input logic [1:0] cl, input logic [1:0] kl,
    input addr_t ab, input addr_t ai, input addr_t aj, input addr_t at,
    input addr_t bb, input addr_t bi, input addr_t bj, input addr_t bt,
    input addr_t ob, input addr_t oi, input addr_t oj);
    op_t o;
    o.mul = mul; o.aid = aid; o.bmode = bm; o.negt = negt;
    o.rl = rl; o.cl = cl; o.kl = kl;
    o.ab = ab; o.ai = ai; o.aj = aj; o.at = at;
    o.bb = bb; o.bi = bi; o.bj = bj; o.bt = bt;
    o.ob = ob; o.oi = oi; o.oj = oj;
    return o;
  endfunction

  // microprogram of the filter step
  function automatic op_t op_f(input op_idx_t idx);
    op_t o;
    case (idx)
      // xp = A x
      5'd0:  o = mk_op(1, 0, B_PLAIN, 0, 3, 0, 3, BASE_A, 4, 0, 1, BASE_X, 0, 0, 1,
                       BASE_XP, 1, 0);
      // t1 = A P
      5'd1:  o = mk_op(1, 0, B_PLAIN, 0, 3, 3, 3, BASE_A, 4, 0, 1, BASE_P, 0, 1, 4,
                       BASE_T1, 4, 1);
      // t2 = t1 A'
      5'd2:  o = mk_op(1, 0, B_PLAIN, 0, 3, 3, 3, BASE_T1, 4, 0, 1, BASE_A, 0, 4, 1,
                       BASE_T2, 4, 1);
      // P = t2 + Q
      5'd3:  o = mk_op(0, 0, B_PLAIN, 0, 3, 3, 0, BASE_T2, 4, 1, 0, BASE_Q, 4, 1, 0,
                       BASE_P, 4, 1);
      // t1 = C P
      5'd4:  o = mk_op(1, 0, B_PLAIN, 0, 1, 3, 3, BASE_C, 4, 0, 1, BASE_P, 0, 1, 4,
                       BASE_T1, 4, 1);
      // t2 = t1 C'
      5'd5:  o = mk_op(1, 0, B_PLAIN, 0, 1, 1, 3, BASE_T1, 4, 0, 1, BASE_C, 0, 4, 1,
                       BASE_T2, 2, 1);
      // S = t2 + R
      5'd6:  o = mk_op(0, 0, B_PLAIN, 0, 1, 1, 0, BASE_T2, 2, 1, 0, BASE_R, 2, 1, 0,
                       BASE_S, 2, 1);
      // det = s0 s3 - s1 s2
      5'd7:  o = mk_op(1, 0, B_PLAIN, 1, 0, 0, 1, BASE_S, 0, 0, 1,
                       BASE_S + 7'd3, 0, 0, STEP_M1, BASE_DET, 0, 0);
      // t1 = P C'
      5'd8:  o = mk_op(1, 0, B_PLAIN, 0, 3, 1, 3, BASE_P, 4, 0, 1, BASE_C, 0, 4, 1,
                       BASE_T1, 2, 1);
      // K = t1 S^-1
      5'd9:  o = mk_op(1, 0, B_PLAIN, 0, 3, 1, 1, BASE_T1, 2, 0, 1, BASE_SI, 0, 1, 2,
                       BASE_K, 2, 1);
      // cx = C xp
      5'd10: o = mk_op(1, 0, B_PLAIN, 0, 1, 0, 3, BASE_C, 4, 0, 1, BASE_XP, 0, 0, 1,
                       BASE_CX, 1, 0);
      // cx = y + (-cx)
      5'd11: o = mk_op(0, 0, B_NEG, 0, 1, 0, 0, BASE_Y, 1, 0, 0, BASE_CX, 1, 0, 0,
                       BASE_CX, 1, 0);
      // kv = K cx
      5'd12: o = mk_op(1, 0, B_PLAIN, 0, 3, 0, 1, BASE_K, 2, 0, 1, BASE_CX, 0, 0, 1,
                       BASE_KV, 1, 0);
      // x = xp + kv
      5'd13: o = mk_op(0, 0, B_PLAIN, 0, 3, 0, 0, BASE_XP, 1, 0, 0, BASE_KV, 1, 0, 0,
                       BASE_X, 1, 0);
      // t1 = K C
      5'd14: o = mk_op(1, 0, B_PLAIN, 0, 3, 3, 1, BASE_K, 2, 0, 1, BASE_C, 0, 1, 4,
                       BASE_T1, 4, 1);
      // t1 = I + (-t1)
      5'd15: o = mk_op(0, 1, B_NEG, 0, 3, 3, 0, BASE_T1, 0, 0, 0, BASE_T1, 4, 1, 0,
                       BASE_T1, 4, 1);
      // t2 = t1 P
      5'd16: o = mk_op(1, 0, B_PLAIN, 0, 3, 3, 3, BASE_T1, 4, 0, 1, BASE_P, 0, 1, 4,
                       BASE_T2, 4, 1);
      // P = t2
      5'd17: o = mk_op(0, 0, B_ZERO, 0, 3, 3, 0, BASE_T2, 4, 1, 0, BASE_T2, 0, 0, 0,
                       BASE_P, 4, 1);
      // x = xp, singular innovation
      default: o = mk_op(0, 0, B_ZERO, 0, 3, 0, 0, BASE_XP, 1, 0, 0, BASE_XP, 0, 0, 0,
                         BASE_X, 1, 0);
    endcase
    return o;
  endfunction

  function automatic word_t sat_w(input logic signed [63:0] v);
    if (v > 64'(WORD_MAX)) return WORD_MAX;
    if (v < 64'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic word_t neg_w(input word_t v);
    if (v == WORD_MIN) return WORD_MAX;
    return -v;
  endfunction

endpackage

// ----- hdl/lkf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkf_div
// Radix-2 restoring divider: quo = sat((num << 16) / den), truncated.
// ----------------------------------------------------------------------------
module lkf_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lkf_pkg::word_t num_i,
  input  lkf_pkg::word_t den_i,
  output logic          done_o,
  output lkf_pkg::word_t quo_o
);
  import lkf_pkg::*;

  localparam int unsigned DQ_W = WORD_W + FRAC_W;
  localparam logic [5:0]  LAST_STEP = 6'(DQ_W - 1);

  logic [DQ_W-1:0]   dq_q;
  logic [WORD_W:0]   rem_q;
  logic [WORD_W-1:0] den_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q, neg_q;

  logic [WORD_W:0]   rem_sh, rem_d;
  logic              ge;
  logic [WORD_W-1:0] num_mag, den_mag;

  assign num_mag = num_i[WORD_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[WORD_W-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q[WORD_W-1:0], dq_q[DQ_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_d   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {num_mag, {FRAC_W{1'b0}}};
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[WORD_W-1] ^ den_i[WORD_W-1];
    end else if (busy_q) begin
      dq_q  <= {dq_q[DQ_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      if (dq_q > {{FRAC_W{1'b0}}, WORD_MIN}) quo_o = WORD_MIN;
      else quo_o = word_t'(~dq_q + 1'b1);
    end else begin
      if (dq_q > {{FRAC_W{1'b0}}, WORD_MAX}) quo_o = WORD_MAX;
      else quo_o = word_t'(dq_q);
    end
  end

  assign done_o = done_q;

endmodule

// ----- hdl/linear_kalman_filter_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_kalman_filter_step
// Q16.16 linear Kalman filter step (4 states, 2 measurements) on one shared
// multiply-accumulate datapath under a microprogrammed sequencer.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i / in_ready_o, operation, target, | in
//          | row, col, load_value, meas_first/second    |
//  out     | out_valid_o / out_ready_i, state_index,    | out
//          | state_value, singular, last                |
//
// A load transfer writes its element in the accept cycle, one item per cycle
// while idle. A step passes each product or elementwise term through the
// read, multiply and accumulate states of the shared multiplier, plus four
// divisions; a singular innovation skips the divisions and sets x = xp.
// in_ready_o is high only while idle; results are shown one at a time and the
// block waits on out_ready_i. Reset clears control and the per-word valid
// bits of the scratch memory, so every stored matrix reads as zero.
//
module linear_kalman_filter_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [2:0]            target_i,
  input  logic [1:0]            row_i,
  input  logic [1:0]            col_i,
  input  lkf_pkg::word_t        load_value_i,
  input  lkf_pkg::word_t        meas_first_i,
  input  lkf_pkg::word_t        meas_second_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            state_index_o,
  output lkf_pkg::word_t        state_value_o,
  output logic                  singular_o,
  output logic                  last_o
);
  import lkf_pkg::*;

  // scratch memory: all matrices, temporaries and the measurement
  word_t                 mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  vld_q;
  word_t                 rda_q, rdb_q;
  addr_t                 ra, rb, wa;
  word_t                 wd;
  logic                  we;

  state_e   state_q, state_d;
  op_idx_t  op_q;
  op_t      op;
  logic [1:0] i_q, j_q, t_q, div_idx_q, out_idx_q;
  logic     singular_q;
  word_t    y0_q, y1_q;
  logic signed [63:0] prod_q;
  logic signed [35:0] acc_q;

  // derived sequencer signals
  addr_t  a_addr, b_addr, o_addr, num_addr;
  logic   term_last, elem_last, accept;
  logic   load_ok;
  addr_t  load_addr;
  logic signed [35:0] term, acc_base, acc_d;
  word_t  a_val, b_val;
  logic   div_start, div_done;
  word_t  div_num, div_quo;

  assign op        = op_f(op_q);
  assign accept    = in_valid_i & in_ready_o;
  assign term_last = (t_q == op.kl);
  assign elem_last = (i_q == op.rl) && (j_q == op.cl);

  assign a_addr = op.ab + op.ai * {5'b0, i_q} + op.aj * {5'b0, j_q} + op.at * {5'b0, t_q};
  assign b_addr = op.bb + op.bi * {5'b0, i_q} + op.bj * {5'b0, j_q} + op.bt * {5'b0, t_q};
  assign o_addr = op.ob + op.oi * {5'b0, i_q} + op.oj * {5'b0, j_q};

  // load decode; out-of-range C, R indexes and unknown targets are dropped
  always_comb begin
    load_ok   = 1'b0;
    load_addr = '0;
    unique case (target_i)
      TGT_A: begin
        load_ok   = 1'b1;
        load_addr = BASE_A + {3'b0, row_i, col_i};
      end
      TGT_C: begin
        load_ok   = !row_i[1];
        load_addr = BASE_C + {4'b0, row_i[0], col_i};
      end
      TGT_Q: begin
        load_ok   = 1'b1;
        load_addr = BASE_Q + {3'b0, row_i, col_i};
      end
      TGT_R: begin
        load_ok   = !row_i[1] && !col_i[1];
        load_addr = BASE_R + {5'b0, row_i[0], col_i[0]};
      end
      TGT_P: begin
        load_ok   = 1'b1;
        load_addr = BASE_P + {3'b0, row_i, col_i};
      end
      TGT_X: begin
        load_ok   = 1'b1;
        load_addr = BASE_X + {5'b0, row_i};
      end
      default: begin
        load_ok   = 1'b0;
        load_addr = '0;
      end
    endcase
  end

  // division numerators: S^-1 = [s3 -s1; -s2 s0] / det
  always_comb begin
    unique case (div_idx_q)
      2'd0:    num_addr = BASE_S + 7'd3;
      2'd1:    num_addr = BASE_S + 7'd1;
      2'd2:    num_addr = BASE_S + 7'd2;
      default: num_addr = BASE_S;
    endcase
  end
  assign div_num = (div_idx_q == 2'd1 || div_idx_q == 2'd2) ? neg_w(rda_q) : rda_q;

  // term datapath
  assign a_val = op.aid ? ((i_q == j_q) ? ONE_Q : '0) : rda_q;
  always_comb begin
    case (op.bmode)
      B_NEG:   b_val = neg_w(rdb_q);
      B_ZERO:  b_val = '0;
      default: b_val = rdb_q;
    endcase
  end

  always_comb begin
    if (op.mul) term = 36'(sat_w(prod_q >>> FRAC_W));
    else        term = prod_q[35:0];
    if (op.negt && t_q != 2'd0) term = -term;
  end
  assign acc_base = (t_q == 2'd0) ? '0 : acc_q;
  assign acc_d    = acc_base + term;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept && operation_i == OP_STEP) state_d = ST_WY0;
      ST_WY0:    state_d = ST_WY1;
      ST_WY1:    state_d = ST_RD;
      ST_RD:     state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC: begin
        if (term_last && elem_last) begin
          if (op_q == OP_DET) state_d = ST_CHK_RD;
          else if (op_q == OP_PCOPY || op_q == OP_XCOPY) state_d = ST_ORD;
          else state_d = ST_RD;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_CHK_RD: state_d = ST_CHK;
      ST_CHK:    state_d = (rda_q == '0) ? ST_RD : ST_DRD;
      ST_DRD:    state_d = ST_DGO;
      ST_DGO:    state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) state_d = (div_idx_q == 2'd3) ? ST_RD : ST_DRD;
      end
      ST_ORD:    state_d = ST_OVLD;
      ST_OVLD: begin
        if (out_ready_i) state_d = (out_idx_q == 2'd3) ? ST_IDLE : ST_ORD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs, memory ports and divider start
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    ra          = '0;
    rb          = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        we         = accept && operation_i == OP_LOAD && load_ok;
        wa         = load_addr;
        wd         = load_value_i;
      end
      ST_WY0: begin
        we = 1'b1;
        wa = BASE_Y;
        wd = y0_q;
      end
      ST_WY1: begin
        we = 1'b1;
        wa = BASE_Y + 7'd1;
        wd = y1_q;
      end
      ST_RD: begin
        ra = a_addr;
        rb = b_addr;
      end
      ST_ACC: begin
        we = term_last;
        wa = o_addr;
        wd = sat_w(64'(acc_d));
      end
      ST_CHK_RD: ra = BASE_DET;
      ST_DRD: begin
        ra = num_addr;
        rb = BASE_DET;
      end
      ST_DGO: div_start = 1'b1;
      ST_DWAIT: begin
        we = div_done;
        wa = BASE_SI + {5'b0, div_idx_q};
        wd = div_quo;
      end
      ST_ORD:  ra = BASE_X + {5'b0, out_idx_q};
      ST_OVLD: begin
        ra          = BASE_X + {5'b0, out_idx_q};
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign state_index_o = out_idx_q;
  assign state_value_o = rda_q;
  assign singular_o    = singular_q;
  assign last_o        = (out_idx_q == 2'd3);

  // memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rda_q <= vld_q[ra] ? mem_q[ra] : '0;
    rdb_q <= vld_q[rb] ? mem_q[rb] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (we) vld_q[wa] <= 1'b1;
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= '0;
      i_q        <= '0;
      j_q        <= '0;
      t_q        <= '0;
      div_idx_q  <= '0;
      out_idx_q  <= '0;
      singular_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && operation_i == OP_STEP) begin
            singular_q <= 1'b0;
            op_q       <= '0;
            i_q        <= '0;
            j_q        <= '0;
            t_q        <= '0;
            out_idx_q  <= '0;
          end
        end
        ST_ACC: begin
          if (!term_last) begin
            t_q <= t_q + 1'b1;
          end else begin
            t_q <= '0;
            if (elem_last) begin
              i_q  <= '0;
              j_q  <= '0;
              op_q <= op_q + 1'b1;
            end else if (j_q == op.cl) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_CHK: begin
          if (rda_q == '0) begin
            singular_q <= 1'b1;
            op_q       <= OP_XCOPY;
          end else begin
            div_idx_q <= '0;
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            div_idx_q <= div_idx_q + 1'b1;
            if (div_idx_q == 2'd3) op_q <= OP_GAIN;
          end
        end
        ST_OVLD: if (out_ready_i) out_idx_q <= out_idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      y0_q <= meas_first_i;
      y1_q <= meas_second_i;
    end
    if (state_q == ST_MUL) begin
      if (op.mul) prod_q <= a_val * b_val;
      else        prod_q <= 64'(a_val) + 64'(b_val);
    end
    if (state_q == ST_ACC) acc_q <= acc_d;
  end

  lkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rdb_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule
